// ===== design/bucketed_window_peak_average_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bucketed window peak and average block
// Shorthand for the concurrent checks of the top level, clocked on clk and
// held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BUCKETED_WINDOW_PEAK_AVERAGE_MACROS_SVH
`define BUCKETED_WINDOW_PEAK_AVERAGE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BWPA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BWPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bwpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bucketed window peak and average package
// Widths, register map, item codes, controller states and the command and
// status bundles shared by the modules of the block.
// ----------------------------------------------------------------------------
package bwpa_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int ELAPSED_W   = 32;
  localparam int BUCKETS_DEF = 64;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_WORD_W  = CFG_ADDR_W - 2;

  // Word index of each configuration register.
  localparam logic [CFG_WORD_W-1:0] REG_BUCKET_TICKS = CFG_WORD_W'(0);

  localparam logic [ELAPSED_W-1:0] TICKS_RESET = ELAPSED_W'(1000);

  // Item kinds on the input channel.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADVANCE,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_UPDATE,
    ST_DIV_START,
    ST_DIV_RUN
  } bwpa_state_t;

  typedef struct packed {
    logic load;
    logic tick;
    logic advance;
    logic scan_step;
    logic update;
    logic div_start;
    logic out_load;
  } bwpa_cmd_t;

  typedef struct packed {
    logic due;
    logic full_next;
    logic scan_last;
    logic div_busy;
  } bwpa_stat_t;

endpackage

// ===== design/bwpa_if.sv =====
// ----------------------------------------------------------------------------
// Bucketed window peak and average channels
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
interface bwpa_in_if;
  import bwpa_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, kind, sample, input ready);
  modport sink (input valid, kind, sample, output ready);
endinterface

interface bwpa_out_if;
  import bwpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] window_max;
  logic [SAMPLE_W-1:0] window_average;
  logic [SAMPLE_W-1:0] bucket_value;

  modport source (output valid, window_max, window_average, bucket_value, input ready);
  modport sink (input valid, window_max, window_average, bucket_value, output ready);
endinterface

// ===== design/bwpa_div.sv =====
// ----------------------------------------------------------------------------
// Bucketed window peak and average divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bwpa_div #(
  parameter int DVD_W = bwpa_pkg::SAMPLE_W + $clog2(bwpa_pkg::BUCKETS_DEF),
  parameter int DVS_W = $clog2(bwpa_pkg::BUCKETS_DEF + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);
  import bwpa_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              ge;

  always_comb begin
    trial    = {rem_r, quo_r[DVD_W-1]};
    diff     = trial - {1'b0, dvs_r};
    ge       = (trial >= {1'b0, dvs_r});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      step_nxt = STEP_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_nxt  = {quo_r[DVD_W-2:0], ge};
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;
endmodule

// ===== design/bwpa_dp.sv =====
// ----------------------------------------------------------------------------
// Bucketed window peak and average datapath
// Bucket ring memory, tick counter, running total and peak, rescan
// accumulator, divider and result register.
// ----------------------------------------------------------------------------
module bwpa_dp #(
  parameter int BUCKETS = bwpa_pkg::BUCKETS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bwpa_pkg::bwpa_cmd_t            cmd,
  output bwpa_pkg::bwpa_stat_t           stat,
  input  logic [bwpa_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [bwpa_pkg::ELAPSED_W-1:0] bucket_ticks,
  output logic [bwpa_pkg::SAMPLE_W-1:0]  window_max,
  output logic [bwpa_pkg::SAMPLE_W-1:0]  window_average,
  output logic [bwpa_pkg::SAMPLE_W-1:0]  bucket_value
);
  import bwpa_pkg::*;

  localparam int IDX_W   = $clog2(BUCKETS);
  localparam int TOTAL_W = SAMPLE_W + IDX_W;
  localparam int CNT_W   = $clog2(BUCKETS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKETS - 1);

  logic [SAMPLE_W-1:0]  mem [BUCKETS];

  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 full_r, full_nxt;
  logic [SAMPLE_W-1:0]  cur_r, cur_nxt;
  logic [SAMPLE_W-1:0]  peak_r, peak_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [IDX_W-1:0]     scan_addr_r, scan_addr_nxt;
  logic                 rd_vld_r;
  logic [SAMPLE_W-1:0]  rd_data_r;
  logic [SAMPLE_W-1:0]  smp_r;
  logic [SAMPLE_W-1:0]  max_out_r, avg_out_r, cur_out_r;

  logic [IDX_W-1:0]     idx_adv;
  logic                 full_adv;
  logic [SAMPLE_W-1:0]  new_cur;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SAMPLE_W-1:0]  wr_data;
  logic [CNT_W-1:0]     count;
  logic                 div_busy;
  logic [TOTAL_W-1:0]   quotient;

  always_comb begin
    idx_adv  = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
    full_adv = full_r | (idx_r == LAST_IDX);
    new_cur  = (smp_r > cur_r) ? smp_r : cur_r;

    idx_nxt       = idx_r;
    full_nxt      = full_r;
    cur_nxt       = cur_r;
    peak_nxt      = peak_r;
    total_nxt     = total_r;
    elapsed_nxt   = elapsed_r;
    scan_addr_nxt = scan_addr_r;

    if (cmd.tick && (elapsed_r != '1)) begin
      elapsed_nxt = elapsed_r + 1'b1;
    end

    if (cmd.advance) begin
      elapsed_nxt   = '0;
      idx_nxt       = idx_adv;
      full_nxt      = full_adv;
      cur_nxt       = '0;
      scan_addr_nxt = '0;
      if (full_adv) begin
        peak_nxt  = '0;
        total_nxt = '0;
      end
    end

    if (cmd.scan_step) begin
      scan_addr_nxt = scan_addr_r + 1'b1;
    end

    // Read data of the rescan arrives in the cycle after its address.
    if (rd_vld_r) begin
      total_nxt = total_r + TOTAL_W'(rd_data_r);
      if (rd_data_r > peak_r) begin
        peak_nxt = rd_data_r;
      end
    end

    if (cmd.update) begin
      cur_nxt   = new_cur;
      total_nxt = total_r - TOTAL_W'(cur_r) + TOTAL_W'(new_cur);
      if (smp_r > peak_r) begin
        peak_nxt = smp_r;
      end
    end
  end

  // The current bucket lives in cur_r; the memory is a write-through copy
  // that is read only by the rescan, after every entry has been written.
  assign wr_en   = cmd.advance | cmd.update;
  assign wr_addr = cmd.advance ? idx_adv : idx_r;
  assign wr_data = cmd.advance ? '0 : new_cur;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      rd_data_r <= mem[scan_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      full_r      <= 1'b0;
      cur_r       <= '0;
      peak_r      <= '0;
      total_r     <= '0;
      elapsed_r   <= '0;
      scan_addr_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      full_r      <= full_nxt;
      cur_r       <= cur_nxt;
      peak_r      <= peak_nxt;
      total_r     <= total_nxt;
      elapsed_r   <= elapsed_nxt;
      scan_addr_r <= scan_addr_nxt;
      rd_vld_r    <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_r <= in_sample;
    end
    if (cmd.out_load) begin
      max_out_r <= peak_r;
      avg_out_r <= quotient[SAMPLE_W-1:0];
      cur_out_r <= cur_r;
    end
  end

  assign count = full_r ? CNT_W'(BUCKETS) : CNT_W'(idx_r) + CNT_W'(1);

  bwpa_div #(
    .DVD_W (TOTAL_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (total_r),
    .divisor  (count),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_comb begin
    stat.due       = (elapsed_r >= bucket_ticks);
    stat.full_next = full_adv;
    stat.scan_last = (scan_addr_r == LAST_IDX);
    stat.div_busy  = div_busy;
  end

  assign window_max     = max_out_r;
  assign window_average = avg_out_r;
  assign bucket_value   = cur_out_r;
endmodule

// ===== design/bwpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bucketed window peak and average controller
// Sequences one item through advance, rescan, update and divide, and owns
// the handshake of both channels.
// ----------------------------------------------------------------------------
module bwpa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_kind,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  bwpa_pkg::bwpa_stat_t stat,
  output bwpa_pkg::bwpa_cmd_t  cmd
);
  import bwpa_pkg::*;

  bwpa_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_kind == KIND_TICK) begin
            cmd.tick  = 1'b1;
            state_nxt = ST_DIV_START;
          end else if (stat.due) begin
            state_nxt = ST_ADVANCE;
          end else begin
            state_nxt = ST_UPDATE;
          end
        end
      end
      ST_ADVANCE: begin
        cmd.advance = 1'b1;
        state_nxt   = stat.full_next ? ST_SCAN : ST_UPDATE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_SCAN_TAIL;
        end
      end
      ST_SCAN_TAIL: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (!stat.div_busy && (!out_valid_r || out_ready)) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule

// ===== design/bucketed_window_peak_average.sv =====
// One item at a time: the next input is taken in the cycle after the result is loaded;
// the bucket rescan (one memory read a cycle) and the bit-serial divider set the time.
// Reset (rst_n low, synchronous) empties the ring; bucket_ticks returns to 1000.
// ----------------------------------------------------------------------------
// Bucketed window peak and average
// Keeps a ring of time buckets, each holding the largest sample seen while it
// was current, and reports the window peak, the average of the filled buckets
// and the current bucket value for every input item.
// ----------------------------------------------------------------------------
`include "bucketed_window_peak_average_macros.svh"

module bucketed_window_peak_average #(
  parameter int BUCKETS = bwpa_pkg::BUCKETS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bwpa_in_if.sink                         in_if,
  bwpa_out_if.source                      out_if,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bwpa_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bwpa_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bwpa_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import bwpa_pkg::*;

  // The block is split into a controller that walks each item through its
  // steps and a datapath that holds the bucket ring and arithmetic. They
  // talk only through the command and status bundles below.
  bwpa_cmd_t  cmd;
  bwpa_stat_t stat;

  logic [ELAPSED_W-1:0] bucket_ticks_r, bucket_ticks_nxt;
  logic                 cfg_wr;
  logic                 cfg_hit;

  // Configuration register. The port never stalls, so a write completes in
  // its access phase. Only the word part of the address is decoded.
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[CFG_ADDR_W-1:2] == REG_BUCKET_TICKS);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;

  always_comb begin
    bucket_ticks_nxt = bucket_ticks_r;
    if (cfg_wr) begin
      bucket_ticks_nxt = pwdata[ELAPSED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_ticks_r <= TICKS_RESET;
    end else begin
      bucket_ticks_r <= bucket_ticks_nxt;
    end
  end

  // Reads of addresses beyond the register map return zero.
  assign prdata = cfg_hit ? CFG_DATA_W'(bucket_ticks_r) : '0;

  bwpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_kind   (in_if.kind),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath captures the sample on the input transfer and drives the
  // result register, which holds a result until the output transfer while
  // the next item is already being worked on.
  bwpa_dp #(
    .BUCKETS (BUCKETS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_sample      (in_if.sample),
    .bucket_ticks   (bucket_ticks_r),
    .window_max     (out_if.window_max),
    .window_average (out_if.window_average),
    .bucket_value   (out_if.bucket_value)
  );

  // After taking an item the block is busy in the cycle after.
  `BWPA_ASSERT_NEXT(a_busy_after_transfer, in_if.valid && in_if.ready, !in_if.ready, "input taken while the previous item is still in work")
  // The divider has finished before a new item comes in.
  `BWPA_ASSERT_SAME(a_div_idle_on_transfer, in_if.valid && in_if.ready, !stat.div_busy, "input transfer while the divider is busy")
  // A new result never overwrites one that has not been transferred.
  `BWPA_ASSERT_SAME(a_result_slot_free, cmd.out_load, !out_if.valid || out_if.ready, "result register overwritten before its transfer")
  // The ring advances only when the bucket time has run out.
  `BWPA_ASSERT_SAME(a_advance_when_due, cmd.advance, stat.due, "bucket advance without elapsed bucket time")
endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the bucketed window peak and average block
// Drives sample and tick items through the valid/ready input channel, moves the
// bucket length through the APB-style register port, and checks every result
// field against an in-bench model of the bucket ring, its running total and
// its peak.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bwpa_pkg::*;

  localparam int BUCKETS = BUCKETS_DEF;
  localparam int IDX_W   = $clog2(BUCKETS);

  // Longest stretch without any transfer before the run is declared hung. The
  // slowest item is a rescan of a full ring, the sender gaps are short and the
  // receiver never stalls for long.
  localparam int QUIET_LIMIT   = 2000;
  // Cycles watched after the last result, so a stray extra result is caught.
  localparam int SETTLE_CYCLES = 120;

  // A word address past the last register; writes there must be dropped.
  localparam logic [CFG_WORD_W-1:0] REG_UNMAPPED = CFG_WORD_W'(1);

  // Receiver ready pattern, one bit per cycle, read in a loop.
  localparam logic [10:0] STALL_WORD = 11'b101_1001_1101;

  typedef enum int {PACE_STEADY, PACE_SHORT_GAPS, PACE_LONG_GAPS} pace_t;
  typedef enum int {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN} sink_t;

  typedef struct {
    logic [SAMPLE_W-1:0] peak;
    logic [SAMPLE_W-1:0] average;
    logic [SAMPLE_W-1:0] bucket;
  } window_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  bwpa_in_if  in_ch ();
  bwpa_out_if out_ch ();

  bucketed_window_peak_average dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Model state: the bucket ring, the window peak and total, the tick counter
  // and the bucket length register as the block should hold them.
  logic [SAMPLE_W-1:0]   bucket_mem [BUCKETS];
  logic [IDX_W-1:0]      cur_bucket;
  logic                  ring_wrapped;
  logic [21:0]           window_total;
  logic [SAMPLE_W-1:0]   window_peak;
  logic [ELAPSED_W-1:0]  tick_count;
  logic [CFG_DATA_W-1:0] ticks_per_bucket;

  // Results still owed by the block, oldest first.
  window_report_t expected_reports [$];

  int failures      = 0;
  int quiet_cycles  = 0;
  int samples_seen  = 0;
  int ticks_seen    = 0;
  int results_seen  = 0;
  int advances_seen = 0;
  int rescans_seen  = 0;
  int settings_seen = 0;

  // Pacing of both channels, set by each test.
  pace_t pace;
  sink_t sink_mode;
  int    burst_left;
  int    stall_pos = 0;

  // Applies one input item to the model and returns the result it causes.
  // A tick only moves the saturating counter. A sample first opens a new
  // bucket when the counter has reached the bucket length; once the ring has
  // wrapped, opening a bucket rebuilds the peak and total from all buckets.
  function automatic window_report_t predict_window_report(
    input logic                kind,
    input logic [SAMPLE_W-1:0] smp
  );
    window_report_t      rep;
    logic [SAMPLE_W-1:0] held;
    int unsigned         filled;
    if (kind == KIND_TICK) begin
      if (tick_count != '1) tick_count++;
    end else begin
      if (tick_count >= ticks_per_bucket) begin
        tick_count = '0;
        advances_seen++;
        if (cur_bucket == IDX_W'(BUCKETS - 1)) begin
          cur_bucket   = '0;
          ring_wrapped = 1'b1;
        end else begin
          cur_bucket++;
        end
        bucket_mem[cur_bucket] = '0;
        if (ring_wrapped) begin
          rescans_seen++;
          window_peak  = '0;
          window_total = '0;
          for (int i = 0; i < BUCKETS; i++) begin
            if (bucket_mem[i] > window_peak) window_peak = bucket_mem[i];
            window_total += 22'(bucket_mem[i]);
          end
        end
      end
      // The bucket's old value leaves the total and its new value joins it.
      held = bucket_mem[cur_bucket];
      window_total -= 22'(held);
      if (smp > window_peak) window_peak = smp;
      if (smp > held) held = smp;
      bucket_mem[cur_bucket] = held;
      window_total += 22'(held);
    end
    // The current bucket always counts, so the divisor is at least one.
    filled      = ring_wrapped ? BUCKETS : int'(cur_bucket) + 1;
    rep.peak    = window_peak;
    rep.average = SAMPLE_W'(window_total / filled);
    rep.bucket  = bucket_mem[cur_bucket];
    return rep;
  endfunction

  function automatic void check_field(
    input string               name,
    input logic [SAMPLE_W-1:0] want,
    input logic [SAMPLE_W-1:0] got
  );
    if (got !== want) begin
      failures++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Sample values that lean on the edges of the range as well as the middle.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_W'($urandom_range(0, 255));
      3:       return SAMPLE_W'(16'hFF00 | $urandom_range(0, 255));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Everything is sampled on the rising edge, before the block's own updates
  // land. Register writes, input transfers and result transfers are handled
  // in that order, so the model sees a new bucket length before any item
  // accepted in a later cycle. The same block runs the watchdog.
  always @(posedge clk) begin : monitor
    window_report_t want;
    if (!rst_n) begin
      foreach (bucket_mem[i]) bucket_mem[i] = '0;
      cur_bucket       = '0;
      ring_wrapped     = 1'b0;
      window_total     = '0;
      window_peak      = '0;
      tick_count       = '0;
      ticks_per_bucket = TICKS_RESET;
      quiet_cycles     = 0;
    end else begin
      quiet_cycles++;
      if (psel && penable && pready) begin
        quiet_cycles = 0;
        // Only the bucket length register exists; other addresses are dropped.
        if (pwrite && paddr[CFG_ADDR_W-1:2] == REG_BUCKET_TICKS) ticks_per_bucket = pwdata;
      end
      if (in_ch.valid && in_ch.ready) begin
        quiet_cycles = 0;
        if (in_ch.kind == KIND_TICK) ticks_seen++;
        else samples_seen++;
        expected_reports.push_back(predict_window_report(in_ch.kind, in_ch.sample));
      end
      if (out_ch.valid && out_ch.ready) begin
        quiet_cycles = 0;
        results_seen++;
        if (expected_reports.size() == 0) begin
          failures++;
          $error("result transfer with no item outstanding: peak %0d, average %0d, bucket %0d",
                 out_ch.window_max, out_ch.window_average, out_ch.bucket_value);
        end else begin
          want = expected_reports.pop_front();
          check_field("window_max", want.peak, out_ch.window_max);
          check_field("window_average", want.average, out_ch.window_average);
          check_field("bucket_value", want.bucket, out_ch.bucket_value);
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding.",
                 QUIET_LIMIT, expected_reports.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // The receiver takes results always, at random, or on a fixed stall word.
  always @(negedge clk) begin
    stall_pos <= (stall_pos == 10) ? 0 : stall_pos + 1;
    case (sink_mode)
      SINK_ALWAYS: out_ch.ready <= 1'b1;
      SINK_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
      default:     out_ch.ready <= STALL_WORD[stall_pos];
    endcase
  end

  // Offers one item and holds it until the block takes it. After each burst
  // the sender may drop valid for a random gap, depending on the pacing.
  // Every task starts and ends just after a falling edge.
  task automatic send_item(input logic kind, input logic [SAMPLE_W-1:0] smp);
    in_ch.valid  <= 1'b1;
    in_ch.kind   <= kind;
    in_ch.sample <= smp;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if (pace != PACE_STEADY) begin
        in_ch.valid <= 1'b0;
        repeat (pace == PACE_LONG_GAPS ? $urandom_range(1, 8) : $urandom_range(1, 2))
          @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // Stops sending and waits until every outstanding result has been taken.
  // The block is idle afterwards, so a register write is safe.
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(
    input logic [CFG_WORD_W-1:0] word,
    input logic [CFG_DATA_W-1:0] value
  );
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {word, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Reads the bucket length back and compares it with the model's copy.
  task automatic check_tick_register();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_BUCKET_TICKS, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== ticks_per_bucket) begin
      failures++;
      $error("bucket_ticks mismatch: expected %0d, got %0d", ticks_per_bucket, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_bucket_length(input logic [CFG_DATA_W-1:0] value);
    write_register(REG_BUCKET_TICKS, value);
    check_tick_register();
    settings_seen++;
  endtask

  // Right after reset the length is 1000 ticks, so nothing here leaves the
  // first bucket: the peak only grows and the average is the bucket itself.
  task automatic test_reset_state();
    check_tick_register();
    send_item(KIND_SAMPLE, 16'h0000);
    send_item(KIND_SAMPLE, 16'hFFFF);
    send_item(KIND_SAMPLE, 16'h8000);
    send_item(KIND_TICK, 16'hFFFF);
    send_item(KIND_TICK, 16'h0000);
    send_item(KIND_SAMPLE, 16'h0001);
    wait_results_drained();
  endtask

  // A zero length makes every sample open a fresh bucket first, so the
  // average drops as empty buckets join the count. Tick items still report.
  task automatic test_zero_length_buckets();
    set_bucket_length('0);
    send_item(KIND_SAMPLE, 16'h00FF);
    send_item(KIND_SAMPLE, 16'hFF00);
    send_item(KIND_SAMPLE, 16'h5555);
    send_item(KIND_TICK, 16'h1234);
    send_item(KIND_SAMPLE, 16'hAAAA);
    send_item(KIND_SAMPLE, 16'h0000);
    wait_results_drained();
  endtask

  // With one tick per bucket a sample opens a bucket only after a tick.
  task automatic test_single_tick_buckets();
    set_bucket_length(32'd1);
    send_item(KIND_SAMPLE, 16'hFFFF);
    send_item(KIND_SAMPLE, 16'h0007);
    send_item(KIND_TICK, 16'h0000);
    send_item(KIND_TICK, 16'hFFFF);
    send_item(KIND_SAMPLE, 16'h0001);
    wait_results_drained();
  endtask

  // A write past the last register must leave the bucket length alone.
  task automatic test_unmapped_register();
    write_register(REG_UNMAPPED, 32'h0000_0007);
    check_tick_register();
    send_item(KIND_TICK, 16'h0F0F);
    send_item(KIND_SAMPLE, 16'hF0F0);
    wait_results_drained();
  endtask

  // The longest length never expires within a run; the saturation of the
  // tick counter itself would take billions of ticks and is out of reach.
  task automatic test_longest_buckets();
    set_bucket_length('1);
    send_item(KIND_TICK, 16'h0000);
    send_item(KIND_SAMPLE, 16'h7FFF);
    send_item(KIND_TICK, 16'h8000);
    send_item(KIND_SAMPLE, 16'hFFFE);
    wait_results_drained();
  endtask

  // Random traffic over several bucket lengths. The short lengths open
  // buckets often, so the ring wraps early and most later samples trigger a
  // full rescan. Pacing and receiver stalls change from phase to phase, and
  // one phase stops halfway until every result is back.
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] lengths     [6] = '{32'd1, 32'd0, 32'd2, 32'd5, '1, 32'd3};
    int                    item_counts [6] = '{220, 160, 180, 150, 60, 180};
    int                    tick_pct    [6] = '{50, 20, 60, 80, 50, 65};
    logic                  kind;
    for (int p = 0; p < 6; p++) begin
      set_bucket_length(lengths[p]);
      pace      = pace_t'(p % 3);
      sink_mode = sink_t'((p + 1) % 3);
      for (int n = 0; n < item_counts[p]; n++) begin
        if (p == 2 && n == item_counts[p] / 2) wait_results_drained();
        kind = ($urandom_range(1, 100) <= tick_pct[p]) ? KIND_TICK : KIND_SAMPLE;
        send_item(kind, pick_sample());
      end
      wait_results_drained();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_SAMPLE;
    in_ch.sample = '0;
    pace         = PACE_STEADY;
    sink_mode    = SINK_PATTERN;
    burst_left   = 1;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_zero_length_buckets();
    test_single_tick_buckets();
    test_unmapped_register();
    test_longest_buckets();
    test_random_traffic();

    // Any result that shows up while nothing is owed is caught here.
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d samples and %0d ticks under %0d bucket lengths; %0d results compared.",
             samples_seen, ticks_seen, settings_seen, results_seen);
    $display("The ring opened %0d buckets, %0d of them with a full window rescan; %0d errors.",
             advances_seen, rescans_seen, failures);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/bwpa_pkg.sv
design/bwpa_if.sv
design/bwpa_div.sv
design/bwpa_dp.sv
design/bwpa_ctrl.sv
design/bucketed_window_peak_average.sv
test/tb.sv
